[hw/rtl/sbeu_pkg.sv]
// shared types, codes and constants of the stack bytecode execute unit
// no dependencies
`timescale 1ns / 1ps

package sbeu_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DATA_W          = 64;

    // function codes of an instruction
    localparam logic [4:0] FN_POP    = 5'd0;
    localparam logic [4:0] FN_CONST  = 5'd1;
    localparam logic [4:0] FN_IMM    = 5'd2;
    localparam logic [4:0] FN_SETLOC = 5'd3;
    localparam logic [4:0] FN_GETLOC = 5'd4;
    localparam logic [4:0] FN_OR     = 5'd5;
    localparam logic [4:0] FN_AND    = 5'd6;
    localparam logic [4:0] FN_EQ     = 5'd7;
    localparam logic [4:0] FN_NE     = 5'd8;
    localparam logic [4:0] FN_LT     = 5'd9;
    localparam logic [4:0] FN_GT     = 5'd10;
    localparam logic [4:0] FN_LE     = 5'd11;
    localparam logic [4:0] FN_GE     = 5'd12;
    localparam logic [4:0] FN_ADD    = 5'd13;
    localparam logic [4:0] FN_SUB    = 5'd14;
    localparam logic [4:0] FN_MUL    = 5'd15;
    localparam logic [4:0] FN_DIV    = 5'd16;
    localparam logic [4:0] FN_MOD    = 5'd17;
    localparam logic [4:0] FN_NEG    = 5'd18;
    localparam logic [4:0] FN_JZ     = 5'd19;
    localparam logic [4:0] FN_JMP    = 5'd20;
    localparam logic [4:0] FN_RET    = 5'd21;

    // instruction classes seen by the back end
    localparam logic [3:0] CL_NOP    = 4'd0;
    localparam logic [3:0] CL_POP    = 4'd1;
    localparam logic [3:0] CL_PUSH   = 4'd2;
    localparam logic [3:0] CL_SETLOC = 4'd3;
    localparam logic [3:0] CL_GETLOC = 4'd4;
    localparam logic [3:0] CL_BIN    = 4'd5;
    localparam logic [3:0] CL_NEG    = 4'd6;
    localparam logic [3:0] CL_JZ     = 4'd7;
    localparam logic [3:0] CL_JMP    = 4'd8;
    localparam logic [3:0] CL_RET    = 4'd9;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_BADLOC = 3'd4;

    typedef struct packed {
        logic [3:0]        cls;
        logic [4:0]        func;
        logic [7:0]        operand;
        logic [DATA_W-1:0] value;
        logic              is_mul;
        logic              is_div;
    } dec_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
    } div_rsp_t;

endpackage

[hw/rtl/sbeu_if.sv]
// item channels of the stack bytecode execute unit: instruction in, result out
// depends on nothing
`timescale 1ns / 1ps

interface sbeu_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         func;
    logic [7:0]         operand;
    logic signed [63:0] const_value;

    modport source (output valid, func, operand, const_value, input ready);
    modport sink (input valid, func, operand, const_value, output ready);
endinterface

interface sbeu_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [63:0] top_value;
    logic [8:0]         stack_depth;
    logic               branch_taken;
    logic [7:0]         branch_offset;
    logic               halted;

    modport source (output valid, status, top_value, stack_depth, branch_taken,
                    branch_offset, halted, input ready);
    modport sink (input valid, status, top_value, stack_depth, branch_taken,
                  branch_offset, halted, output ready);
endinterface

[hw/rtl/stack_bytecode_execute_unit.sv]
// top level of the stack bytecode execute unit
// depends on sbeu_pkg, sbeu_if, sbeu_front, sbeu_queue, sbeu_div, sbeu_back
`timescale 1ns / 1ps

// executes one decoded instruction of a 64-bit integer stack machine per item
// on the instr channel and returns exactly one item on the result channel.
// a front stage takes and classifies each item, a two-entry queue decouples it
// from the back end, which runs one item at a time on a stack ram with
// registered read and keeps the top of stack in a register. most items pass
// through ram read, evaluate and commit, mul adds multiply steps because it is
// built from three 32x32 partial products, and div or mod wait in between on
// the one-bit-per-cycle divider. errors leave the stack as it
// was and are reported in status; after a ret every later item repeats the
// returned value with halted set. the stack ram needs no clearing after reset.

module stack_bytecode_execute_unit #(
    parameter int STACK_DEPTH = sbeu_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sbeu_in_if.sink     instr,
    sbeu_out_if.source  result
);

    // front to queue
    logic               f_valid;
    logic               f_ready;
    sbeu_pkg::dec_t     f_item;

    // queue to back end
    logic               q_valid;
    logic               q_ready;
    sbeu_pkg::dec_t     q_item;

    // divider handshake
    sbeu_pkg::div_req_t div_req;
    sbeu_pkg::div_rsp_t div_rsp;

    sbeu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr),
        .dec_valid (f_valid),
        .dec_ready (f_ready),
        .dec_item  (f_item)
    );

    sbeu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    sbeu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer, stack ram and result register
    sbeu_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .result  (result)
    );

endmodule

[hw/rtl/sbeu_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sbeu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/sbeu_front.sv]
// front end: accepts instruction items and classifies them for the back end
// depends on sbeu_pkg, sbeu_if
`timescale 1ns / 1ps

module sbeu_front (
    input  logic             clk,
    input  logic             rst_n,
    sbeu_in_if.sink          instr,
    output logic             dec_valid,
    input  logic             dec_ready,
    output sbeu_pkg::dec_t   dec_item
);

    logic           valid_reg;
    logic           valid_next;
    sbeu_pkg::dec_t item_reg;
    sbeu_pkg::dec_t decoded;
    logic           accept;

    assign instr.ready = !valid_reg || dec_ready;
    assign accept      = instr.valid && instr.ready;
    assign dec_valid   = valid_reg;
    assign dec_item    = item_reg;

    always_comb
    begin
        decoded.func    = instr.func;
        decoded.operand = instr.operand;
        decoded.value   = {{(sbeu_pkg::DATA_W - 8){1'b0}}, instr.operand};
        decoded.is_mul  = (instr.func == sbeu_pkg::FN_MUL);
        decoded.is_div  = (instr.func == sbeu_pkg::FN_DIV) || (instr.func == sbeu_pkg::FN_MOD);
        unique case (instr.func) inside
            sbeu_pkg::FN_POP:    decoded.cls = sbeu_pkg::CL_POP;
            sbeu_pkg::FN_CONST:
            begin
                decoded.cls   = sbeu_pkg::CL_PUSH;
                decoded.value = instr.const_value;
            end
            sbeu_pkg::FN_IMM:    decoded.cls = sbeu_pkg::CL_PUSH;
            sbeu_pkg::FN_SETLOC: decoded.cls = sbeu_pkg::CL_SETLOC;
            sbeu_pkg::FN_GETLOC: decoded.cls = sbeu_pkg::CL_GETLOC;
            sbeu_pkg::FN_OR, sbeu_pkg::FN_AND, sbeu_pkg::FN_EQ, sbeu_pkg::FN_NE,
            sbeu_pkg::FN_LT, sbeu_pkg::FN_GT, sbeu_pkg::FN_LE, sbeu_pkg::FN_GE,
            sbeu_pkg::FN_ADD, sbeu_pkg::FN_SUB, sbeu_pkg::FN_MUL, sbeu_pkg::FN_DIV,
            sbeu_pkg::FN_MOD:    decoded.cls = sbeu_pkg::CL_BIN;
            sbeu_pkg::FN_NEG:    decoded.cls = sbeu_pkg::CL_NEG;
            sbeu_pkg::FN_JZ:     decoded.cls = sbeu_pkg::CL_JZ;
            sbeu_pkg::FN_JMP:    decoded.cls = sbeu_pkg::CL_JMP;
            sbeu_pkg::FN_RET:    decoded.cls = sbeu_pkg::CL_RET;
            default:             decoded.cls = sbeu_pkg::CL_NOP;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (dec_ready)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= decoded;
        end
    end

endmodule

[hw/rtl/sbeu_queue.sv]
// short queue of decoded items between front end and back end
// depends on sbeu_pkg
`timescale 1ns / 1ps

module sbeu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sbeu_pkg::dec_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output sbeu_pkg::dec_t out_item
);

    localparam int PW = (sbeu_pkg::QUEUE_DEPTH > 1) ? $clog2(sbeu_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(sbeu_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(sbeu_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(sbeu_pkg::QUEUE_DEPTH);

    sbeu_pkg::dec_t  entry_reg [sbeu_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hw/rtl/sbeu_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating
// depends on sbeu_pkg
`timescale 1ns / 1ps

module sbeu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  sbeu_pkg::div_req_t req,
    output sbeu_pkg::div_rsp_t rsp
);

    localparam int W  = sbeu_pkg::DATA_W;
    localparam int NW = $clog2(W);
    localparam logic [NW-1:0] LAST_STEP = NW'(W - 1);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  den_next;
    logic          neg_q_reg;
    logic          neg_q_next;
    logic          neg_r_reg;
    logic          neg_r_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign rsp.done = done_reg;
    assign rsp.quo  = neg_q_reg ? (W'(0) - quo_reg) : quo_reg;
    assign rsp.rem  = neg_r_reg ? (W'(0) - rem_reg) : rem_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = req.num[W-1] ? (W'(0) - req.num) : req.num;
            den_next   = req.den[W-1] ? (W'(0) - req.den) : req.den;
            neg_q_next = req.num[W-1] ^ req.den[W-1];
            neg_r_next = req.num[W-1];
        end
        else if (busy_reg)
        begin
            // restoring step on the magnitudes
            quo_next = {quo_reg[W-2:0], !diff[W]};
            rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

endmodule

[hw/rtl/sbeu_back.sv]
// back end: sequencer that carries out one item on the stack ram and result register
// depends on sbeu_pkg, sbeu_if, sbeu_ram
`timescale 1ns / 1ps

module sbeu_back #(
    parameter int STACK_DEPTH = sbeu_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  sbeu_pkg::dec_t     q_item,
    output sbeu_pkg::div_req_t div_req,
    input  sbeu_pkg::div_rsp_t div_rsp,
    sbeu_out_if.source         result
);

    localparam int W     = sbeu_pkg::DATA_W;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (SP_W > 8) ? SP_W : 8;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic            halt_reg, halt_next;
    logic            out_valid_reg, out_valid_next;
    logic [W-1:0]    tos_reg, tos_next;
    logic [W-1:0]    ret_val_reg, ret_val_next;
    sbeu_pkg::dec_t  cur_reg, cur_next;
    logic [2:0]      st_reg, st_next;
    logic            wr_en_reg, wr_en_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic [W-1:0]    wdata_reg, wdata_next;
    logic [W-1:0]    ntos_reg, ntos_next;
    logic            tos_upd_reg, tos_upd_next;
    logic [SP_W-1:0] new_sp_reg, new_sp_next;
    logic            br_reg, br_next;
    logic            ret_reg, ret_next;
    logic [W-1:0]    opa_reg, opa_next;
    logic [1:0]      mstep_reg, mstep_next;
    logic [W-1:0]    prod_reg, prod_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [2:0]      o_status_reg, o_status_next;
    logic [W-1:0]    o_top_reg, o_top_next;
    logic [8:0]      o_depth_reg, o_depth_next;
    logic            o_br_reg, o_br_next;
    logic [7:0]      o_off_reg, o_off_next;
    logic            o_halt_reg, o_halt_next;

    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [W-1:0]    ram_rdata;
    logic            sp_lt1, sp_lt2, full, opd_bad, opd_top, opd_second;
    logic [31:0]     mul_x, mul_y;
    logic [W-1:0]    loc_val;

    function automatic logic [W-1:0] alu(input logic [4:0] f, input logic [W-1:0] a,
                                         input logic [W-1:0] b);
        logic r;
        r = 1'b0;
        case (f)
            sbeu_pkg::FN_OR:  r = (a != '0) || (b != '0);
            sbeu_pkg::FN_AND: r = (a != '0) && (b != '0);
            sbeu_pkg::FN_EQ:  r = (a == b);
            sbeu_pkg::FN_NE:  r = (a != b);
            sbeu_pkg::FN_LT:  r = ($signed(a) < $signed(b));
            sbeu_pkg::FN_GT:  r = ($signed(a) > $signed(b));
            sbeu_pkg::FN_LE:  r = ($signed(a) <= $signed(b));
            sbeu_pkg::FN_GE:  r = ($signed(a) >= $signed(b));
            sbeu_pkg::FN_ADD: return a + b;
            sbeu_pkg::FN_SUB: return a - b;
            default:          r = 1'b0;
        endcase
        return {{(W - 1){1'b0}}, r};
    endfunction

    sbeu_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (wdata_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result.valid         = out_valid_reg;
    assign result.status        = o_status_reg;
    assign result.top_value     = o_top_reg;
    assign result.stack_depth   = o_depth_reg;
    assign result.branch_taken  = o_br_reg;
    assign result.branch_offset = o_off_reg;
    assign result.halted        = o_halt_reg;

    assign sp_lt1     = (sp_reg == '0);
    assign sp_lt2     = (sp_reg < SP_W'(2));
    assign full       = (sp_reg >= SP_FULL);
    assign opd_bad    = (CMP_W'(cur_reg.operand) >= CMP_W'(sp_reg));
    assign opd_top    = (CMP_W'(cur_reg.operand) + CMP_W'(1) == CMP_W'(sp_reg));
    assign opd_second = (CMP_W'(cur_reg.operand) + CMP_W'(2) == CMP_W'(sp_reg));
    assign loc_val    = opd_top ? tos_reg : ram_rdata;
    assign mul_x      = (mstep_reg == 2'd2) ? opa_reg[63:32] : opa_reg[31:0];
    assign mul_y      = (mstep_reg == 2'd1) ? tos_reg[63:32] : tos_reg[31:0];

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        halt_next      = halt_reg;
        out_valid_next = out_valid_reg;
        tos_next       = tos_reg;
        ret_val_next   = ret_val_reg;
        cur_next       = cur_reg;
        st_next        = st_reg;
        wr_en_next     = wr_en_reg;
        wr_addr_next   = wr_addr_reg;
        wdata_next     = wdata_reg;
        ntos_next      = ntos_reg;
        tos_upd_next   = tos_upd_reg;
        new_sp_next    = new_sp_reg;
        br_next        = br_reg;
        ret_next       = ret_reg;
        opa_next       = opa_reg;
        mstep_next     = mstep_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        o_status_next  = o_status_reg;
        o_top_next     = o_top_reg;
        o_depth_next   = o_depth_reg;
        o_br_next      = o_br_reg;
        o_off_next     = o_off_reg;
        o_halt_next    = o_halt_reg;
        q_ready        = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        div_req.start  = 1'b0;
        div_req.num    = ram_rdata;
        div_req.den    = tos_reg;

        if (q_item.cls == sbeu_pkg::CL_GETLOC)
        begin
            ram_raddr = AW'(q_item.operand);
        end
        else
        begin
            ram_raddr = AW'(sp_reg - SP_W'(2));
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready    = 1'b1;
                    ram_re     = 1'b1;
                    cur_next   = q_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next      = sbeu_pkg::ST_OK;
                wr_en_next   = 1'b0;
                wr_addr_next = AW'(sp_reg);
                wdata_next   = cur_reg.value;
                ntos_next    = cur_reg.value;
                tos_upd_next = 1'b0;
                new_sp_next  = sp_reg;
                br_next      = 1'b0;
                ret_next     = 1'b0;
                opa_next     = ram_rdata;
                state_next   = S_COMMIT;
                if (!halt_reg)
                begin
                    case (cur_reg.cls)
                        sbeu_pkg::CL_POP:
                        begin
                            if (sp_lt1)
                            begin
                                st_next = sbeu_pkg::ST_UNDER;
                            end
                            else
                            begin
                                new_sp_next  = sp_reg - SP_W'(1);
                                ntos_next    = ram_rdata;
                                tos_upd_next = 1'b1;
                            end
                        end
                        sbeu_pkg::CL_PUSH:
                        begin
                            if (full)
                            begin
                                st_next = sbeu_pkg::ST_OVER;
                            end
                            else
                            begin
                                wr_en_next   = 1'b1;
                                tos_upd_next = 1'b1;
                                new_sp_next  = sp_reg + SP_W'(1);
                            end
                        end
                        sbeu_pkg::CL_SETLOC:
                        begin
                            if (sp_lt1)
                            begin
                                st_next = sbeu_pkg::ST_UNDER;
                            end
                            else if (opd_bad)
                            begin
                                st_next = sbeu_pkg::ST_BADLOC;
                            end
                            else
                            begin
                                wr_en_next   = 1'b1;
                                wr_addr_next = AW'(cur_reg.operand);
                                wdata_next   = tos_reg;
                                if (!opd_top)
                                begin
                                    // slot just below the top becomes the top
                                    new_sp_next  = sp_reg - SP_W'(1);
                                    tos_upd_next = 1'b1;
                                    ntos_next    = opd_second ? tos_reg : ram_rdata;
                                end
                            end
                        end
                        sbeu_pkg::CL_GETLOC:
                        begin
                            if (opd_bad)
                            begin
                                st_next = sbeu_pkg::ST_BADLOC;
                            end
                            else if (full)
                            begin
                                st_next = sbeu_pkg::ST_OVER;
                            end
                            else
                            begin
                                wr_en_next   = 1'b1;
                                wdata_next   = loc_val;
                                ntos_next    = loc_val;
                                tos_upd_next = 1'b1;
                                new_sp_next  = sp_reg + SP_W'(1);
                            end
                        end
                        sbeu_pkg::CL_BIN:
                        begin
                            if (sp_lt2)
                            begin
                                st_next = sbeu_pkg::ST_UNDER;
                            end
                            else if (cur_reg.is_div && (tos_reg == '0))
                            begin
                                st_next = sbeu_pkg::ST_DIVZ;
                            end
                            else
                            begin
                                wr_en_next   = 1'b1;
                                wr_addr_next = AW'(sp_reg - SP_W'(2));
                                tos_upd_next = 1'b1;
                                new_sp_next  = sp_reg - SP_W'(1);
                                if (cur_reg.is_mul)
                                begin
                                    mstep_next = 2'd0;
                                    state_next = S_MUL;
                                end
                                else if (cur_reg.is_div)
                                begin
                                    div_req.start = 1'b1;
                                    state_next    = S_DIV;
                                end
                                else
                                begin
                                    wdata_next = alu(cur_reg.func, ram_rdata, tos_reg);
                                    ntos_next  = alu(cur_reg.func, ram_rdata, tos_reg);
                                end
                            end
                        end
                        sbeu_pkg::CL_NEG:
                        begin
                            if (sp_lt1)
                            begin
                                st_next = sbeu_pkg::ST_UNDER;
                            end
                            else
                            begin
                                wr_en_next   = 1'b1;
                                wr_addr_next = AW'(sp_reg - SP_W'(1));
                                wdata_next   = W'(0) - tos_reg;
                                ntos_next    = W'(0) - tos_reg;
                                tos_upd_next = 1'b1;
                            end
                        end
                        sbeu_pkg::CL_JZ:
                        begin
                            if (sp_lt1)
                            begin
                                st_next = sbeu_pkg::ST_UNDER;
                            end
                            else
                            begin
                                br_next = (tos_reg == '0);
                            end
                        end
                        sbeu_pkg::CL_JMP:
                        begin
                            br_next = 1'b1;
                        end
                        sbeu_pkg::CL_RET:
                        begin
                            if (sp_lt1)
                            begin
                                st_next = sbeu_pkg::ST_UNDER;
                            end
                            else
                            begin
                                new_sp_next = sp_reg - SP_W'(1);
                                ret_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                            st_next = sbeu_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // low 64 bits from three 32x32 partial products
                mstep_next = mstep_reg + 2'd1;
                prod_next  = W'(mul_x * mul_y);
                case (mstep_reg)
                    2'd1: acc_next = prod_reg;
                    2'd2: acc_next = acc_reg + {prod_reg[31:0], 32'b0};
                    2'd3:
                    begin
                        wdata_next = acc_reg + {prod_reg[31:0], 32'b0};
                        ntos_next  = acc_reg + {prod_reg[31:0], 32'b0};
                        state_next = S_COMMIT;
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    wdata_next = (cur_reg.func == sbeu_pkg::FN_DIV) ? div_rsp.quo : div_rsp.rem;
                    ntos_next  = (cur_reg.func == sbeu_pkg::FN_DIV) ? div_rsp.quo : div_rsp.rem;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    ram_we         = wr_en_reg;
                    sp_next        = new_sp_reg;
                    out_valid_next = 1'b1;
                    o_status_next  = st_reg;
                    o_depth_next   = 9'(new_sp_reg);
                    o_br_next      = br_reg;
                    o_off_next     = br_reg ? cur_reg.operand : 8'd0;
                    o_halt_next    = halt_reg || ret_reg;
                    if (tos_upd_reg)
                    begin
                        tos_next = ntos_reg;
                    end
                    if (ret_reg)
                    begin
                        halt_next    = 1'b1;
                        ret_val_next = tos_reg;
                    end
                    if (halt_reg)
                    begin
                        o_top_next = ret_val_reg;
                    end
                    else if (ret_reg)
                    begin
                        o_top_next = tos_reg;
                    end
                    else if (new_sp_reg == '0)
                    begin
                        o_top_next = '0;
                    end
                    else
                    begin
                        o_top_next = tos_upd_reg ? ntos_reg : tos_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        ret_val_reg  <= ret_val_next;
        cur_reg      <= cur_next;
        st_reg       <= st_next;
        wr_en_reg    <= wr_en_next;
        wr_addr_reg  <= wr_addr_next;
        wdata_reg    <= wdata_next;
        ntos_reg     <= ntos_next;
        tos_upd_reg  <= tos_upd_next;
        new_sp_reg   <= new_sp_next;
        br_reg       <= br_next;
        ret_reg      <= ret_next;
        opa_reg      <= opa_next;
        mstep_reg    <= mstep_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        o_status_reg <= o_status_next;
        o_top_reg    <= o_top_next;
        o_depth_reg  <= o_depth_next;
        o_br_reg     <= o_br_next;
        o_off_reg    <= o_off_next;
        o_halt_reg   <= o_halt_next;
    end

endmodule

[tb/sv/testbench.sv]
// self-checking testbench of the stack bytecode execute unit
// depends on sbeu_pkg, sbeu_if and the stack_bytecode_execute_unit rtl
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = sbeu_pkg::STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINUS_ONE = '1;
    localparam logic [4:0] FN_UNUSED = 5'd31;

    // one instruction item and the result item it should cause
    typedef struct {
        logic [4:0]  func;
        logic [7:0]  operand;
        logic [63:0] const_value;
    } instr_t;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] top_value;
        logic [8:0]  stack_depth;
        logic        branch_taken;
        logic [7:0]  branch_offset;
        logic        halted;
    } outcome_t;

    logic clk;
    logic rst_n;

    sbeu_in_if  instr_ch();
    sbeu_out_if result_ch();

    stack_bytecode_execute_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    // predictor state: value stack, entry count and halt latch
    logic [63:0] vstack [DEPTH];
    int          entries;
    logic        stopped;

    instr_t   pending_q [$];
    outcome_t outcome_q [$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int fail_count;
    int sent_count;
    int checked_count;
    int idle_cycles;
    int gen_depth;

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // predictor: one instruction in, one outcome out, stack state updated
    // ------------------------------------------------------------------
    function automatic logic [63:0] eval_binary(logic [4:0] f, logic [63:0] a,
                                                logic [63:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = a;
        sb = b;
        case (f)
            sbeu_pkg::FN_OR:  return {63'd0, (a != 0) || (b != 0)};
            sbeu_pkg::FN_AND: return {63'd0, (a != 0) && (b != 0)};
            sbeu_pkg::FN_EQ:  return {63'd0, a == b};
            sbeu_pkg::FN_NE:  return {63'd0, a != b};
            sbeu_pkg::FN_LT:  return {63'd0, sa < sb};
            sbeu_pkg::FN_GT:  return {63'd0, sa > sb};
            sbeu_pkg::FN_LE:  return {63'd0, sa <= sb};
            sbeu_pkg::FN_GE:  return {63'd0, sa >= sb};
            sbeu_pkg::FN_ADD: return a + b;
            sbeu_pkg::FN_SUB: return a - b;
            sbeu_pkg::FN_MUL: return a * b;
            sbeu_pkg::FN_DIV:
            begin
                // most negative over minus one wraps back to itself
                if (a == MOST_NEG && b == MINUS_ONE) return a;
                return sa / sb;
            end
            sbeu_pkg::FN_MOD:
            begin
                if (b == MINUS_ONE) return 64'd0;
                return sa % sb;
            end
            default: return 64'd0;
        endcase
    endfunction

    function automatic outcome_t execute_instr(instr_t it);
        outcome_t o;
        logic     returned;
        o = '{sbeu_pkg::ST_OK, 64'd0, 9'd0, 1'b0, 8'd0, 1'b0};
        returned = 1'b0;
        // after a return everything is ignored and the popped value repeats
        if (stopped)
        begin
            o.top_value = (entries < DEPTH) ? vstack[entries] : 64'd0;
            o.stack_depth = entries[8:0];
            o.halted = 1'b1;
            return o;
        end
        case (it.func)
            sbeu_pkg::FN_POP:
                if (entries < 1) o.status = sbeu_pkg::ST_UNDER;
                else entries--;
            sbeu_pkg::FN_CONST, sbeu_pkg::FN_IMM:
                if (entries >= DEPTH) o.status = sbeu_pkg::ST_OVER;
                else
                begin
                    vstack[entries] = (it.func == sbeu_pkg::FN_CONST) ? it.const_value
                                                                      : {56'd0, it.operand};
                    entries++;
                end
            sbeu_pkg::FN_SETLOC:
                if (entries < 1) o.status = sbeu_pkg::ST_UNDER;
                else if (it.operand >= entries) o.status = sbeu_pkg::ST_BADLOC;
                else
                begin
                    vstack[it.operand] = vstack[entries-1];
                    // writing the top slot itself keeps the entry
                    if (it.operand != entries - 1) entries--;
                end
            sbeu_pkg::FN_GETLOC:
                // bad index wins over overflow
                if (it.operand >= entries) o.status = sbeu_pkg::ST_BADLOC;
                else if (entries >= DEPTH) o.status = sbeu_pkg::ST_OVER;
                else
                begin
                    vstack[entries] = vstack[it.operand];
                    entries++;
                end
            sbeu_pkg::FN_NEG:
                if (entries < 1) o.status = sbeu_pkg::ST_UNDER;
                else vstack[entries-1] = -vstack[entries-1];
            sbeu_pkg::FN_JZ:
                // reads the top without popping it
                if (entries < 1) o.status = sbeu_pkg::ST_UNDER;
                else if (vstack[entries-1] == 0) o.branch_taken = 1'b1;
            sbeu_pkg::FN_JMP:
                o.branch_taken = 1'b1;
            sbeu_pkg::FN_RET:
                if (entries < 1) o.status = sbeu_pkg::ST_UNDER;
                else
                begin
                    entries--;
                    returned = 1'b1;
                    stopped = 1'b1;
                end
            default:
                if (it.func >= sbeu_pkg::FN_OR && it.func <= sbeu_pkg::FN_MOD)
                begin
                    if (entries < 2) o.status = sbeu_pkg::ST_UNDER;
                    else if ((it.func == sbeu_pkg::FN_DIV || it.func == sbeu_pkg::FN_MOD)
                             && vstack[entries-1] == 0)
                        o.status = sbeu_pkg::ST_DIVZ;
                    else
                    begin
                        vstack[entries-2] = eval_binary(it.func, vstack[entries-2],
                                                        vstack[entries-1]);
                        entries--;
                    end
                end
                // unused codes fall through as a no-op
        endcase
        if (returned) o.top_value = vstack[entries];
        else o.top_value = (entries == 0) ? 64'd0 : vstack[entries-1];
        o.stack_depth = entries[8:0];
        o.branch_offset = o.branch_taken ? it.operand : 8'd0;
        o.halted = stopped;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // driver: takes the next pending item, unless it idles at random, when the channel is free
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        instr_t it;
        if (!rst_n)
        begin
            instr_ch.valid       <= 1'b0;
            instr_ch.func        <= '0;
            instr_ch.operand     <= '0;
            instr_ch.const_value <= '0;
            entries    = 0;
            stopped    = 1'b0;
            sent_count = 0;
        end
        else
        begin
            // an accepted item goes through the predictor right here
            if (instr_ch.valid && instr_ch.ready)
            begin
                it = '{instr_ch.func, instr_ch.operand, instr_ch.const_value};
                outcome_q.push_back(execute_instr(it));
                sent_count++;
            end
            if (!instr_ch.valid || instr_ch.ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    it = pending_q.pop_front();
                    instr_ch.valid       <= 1'b1;
                    instr_ch.func        <= it.func;
                    instr_ch.operand     <= it.operand;
                    instr_ch.const_value <= it.const_value;
                end
                else
                    instr_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure and field-by-field comparison
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            checked_count = 0;
            fail_count    = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                checked_count++;
                if (outcome_q.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (result_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               result_ch.status);
                        fail_count++;
                    end
                    if (result_ch.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0h, got %0h", want.top_value,
                               result_ch.top_value);
                        fail_count++;
                    end
                    if (result_ch.stack_depth !== want.stack_depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d", want.stack_depth,
                               result_ch.stack_depth);
                        fail_count++;
                    end
                    if (result_ch.branch_taken !== want.branch_taken)
                    begin
                        $error("branch_taken: expected %0d, got %0d",
                               want.branch_taken, result_ch.branch_taken);
                        fail_count++;
                    end
                    if (result_ch.branch_offset !== want.branch_offset)
                    begin
                        $error("branch_offset: expected %0d, got %0d",
                               want.branch_offset, result_ch.branch_offset);
                        fail_count++;
                    end
                    if (result_ch.halted !== want.halted)
                    begin
                        $error("halted: expected %0d, got %0d", want.halted,
                               result_ch.halted);
                        fail_count++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles without any item moving on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (instr_ch.valid && instr_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // queues an item and tracks roughly how deep the stack will be
    task automatic queue_instr(logic [4:0] f, logic [7:0] opd, logic [63:0] cv);
        pending_q.push_back('{f, opd, cv});
        case (f)
            sbeu_pkg::FN_POP:   if (gen_depth > 0) gen_depth--;
            sbeu_pkg::FN_CONST, sbeu_pkg::FN_IMM:
                if (gen_depth < DEPTH) gen_depth++;
            sbeu_pkg::FN_SETLOC:
                if (gen_depth > 0 && opd < gen_depth && opd != gen_depth - 1)
                    gen_depth--;
            sbeu_pkg::FN_GETLOC:
                if (opd < gen_depth && gen_depth < DEPTH) gen_depth++;
            default:
                if (f >= sbeu_pkg::FN_OR && f <= sbeu_pkg::FN_MOD && gen_depth >= 2)
                    gen_depth--;
        endcase
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return 64'd1;
            2: return MINUS_ONE;
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return 64'($signed($urandom_range(20)) - 10);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one random instruction, biased by the expected depth
    task automatic queue_random();
        int          pick;
        logic [7:0]  opd;
        pick = $urandom_range(99);
        opd = 8'($urandom_range(255));
        if (gen_depth < 2 && pick < 70) pick = 0;
        if (gen_depth > 40 && pick < 30) pick = 40;
        if (pick < 22)
            queue_instr(sbeu_pkg::FN_CONST, opd, pick_value());
        else if (pick < 34)
            queue_instr(sbeu_pkg::FN_IMM, opd, {$urandom, $urandom});
        else if (pick < 42)
            queue_instr(sbeu_pkg::FN_POP, opd, {$urandom, $urandom});
        else if (pick < 56)
        begin
            // local index mostly in range, sometimes past the depth
            if (gen_depth > 0 && $urandom_range(4) != 0)
                opd = 8'($urandom_range(gen_depth - 1));
            queue_instr(($urandom_range(1) != 0) ? sbeu_pkg::FN_SETLOC
                                                 : sbeu_pkg::FN_GETLOC, opd,
                        {$urandom, $urandom});
        end
        else if (pick < 90)
            queue_instr(5'($urandom_range(sbeu_pkg::FN_OR, sbeu_pkg::FN_MOD)), opd,
                        {$urandom, $urandom});
        else if (pick < 97)
            queue_instr(5'($urandom_range(sbeu_pkg::FN_NEG, sbeu_pkg::FN_JMP)), opd,
                        {$urandom, $urandom});
        else
            queue_instr(5'($urandom_range(22, 31)), opd, {$urandom, $urandom});
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || instr_ch.valid || outcome_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sender_idle_pct   = 21;
        receiver_idle_pct = 52;
        gen_depth         = 0;
        @(posedge rst_n);

        // directed: empty stack errors, divide corner cases, locals, branches
        queue_instr(sbeu_pkg::FN_POP, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_JZ, 8'd9, 64'd0);
        queue_instr(sbeu_pkg::FN_RET, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_SETLOC, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_GETLOC, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_CONST, 8'd0, MOST_NEG);
        queue_instr(sbeu_pkg::FN_CONST, 8'd0, MINUS_ONE);
        queue_instr(sbeu_pkg::FN_DIV, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_CONST, 8'd0, MINUS_ONE);
        queue_instr(sbeu_pkg::FN_MOD, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_IMM, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_DIV, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_MOD, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_JZ, 8'd7, 64'd0);
        queue_instr(sbeu_pkg::FN_JMP, 8'd255, 64'd0);
        queue_instr(sbeu_pkg::FN_SETLOC, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_SETLOC, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_GETLOC, 8'd5, 64'd0);
        queue_instr(sbeu_pkg::FN_GETLOC, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_CONST, 8'd0, MOST_POS);
        queue_instr(sbeu_pkg::FN_IMM, 8'd255, 64'd0);
        queue_instr(sbeu_pkg::FN_ADD, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_NEG, 8'd0, 64'd0);
        queue_instr(sbeu_pkg::FN_MUL, 8'd0, 64'd0);
        queue_instr(FN_UNUSED, 8'd0, 64'd0);

        // sender holds off until every outcome is back
        wait_drained();

        // fill to overflow, then two getlocs on the full stack, then drain
        repeat (DEPTH + 3 - gen_depth) queue_instr(sbeu_pkg::FN_IMM, 8'($urandom), 64'd0);
        queue_instr(sbeu_pkg::FN_GETLOC, 8'd3, 64'd0);
        queue_instr(sbeu_pkg::FN_GETLOC, 8'd255, 64'd0);
        while (gen_depth > 0) queue_instr(sbeu_pkg::FN_POP, 8'd0, 64'd0);

        repeat (85) queue_random();
        wait_drained();

        sender_idle_pct   = 52;
        receiver_idle_pct = 21;
        repeat (85) queue_random();
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        repeat (85) queue_random();
        // return, then a few items that must all be ignored
        queue_instr(sbeu_pkg::FN_IMM, 8'h5a, 64'd0);
        queue_instr(sbeu_pkg::FN_RET, 8'd0, 64'd0);
        repeat (8) queue_random();
        wait_drained();
        repeat (100) @(posedge clk);

        $display("ran %0d instruction items, %0d results checked, covering", sent_count,
                 checked_count);
        $display("stack errors, full stack, divide corners, branches and halt");
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
